// File: rtl/pct_pkg.sv
`default_nettype none
package pct_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_BITS_DEF  = 12;
  localparam int DATA_BITS_DEF = 32;

  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_REMOVE    = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_OVERWRITE = 3'd3;
  localparam logic [2:0] CMD_TEST      = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_RM_MOVE,
    S_RM_CLR,
    S_RD_WAIT,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// File: rtl/pct_ram.sv
`default_nettype none
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/packed_component_table.sv
// Every command first reads the key map; add, overwrite, presence test and
// failed commands then answer, read adds a dense RAM read, and remove adds a
// last-slot read, the move and a key map clear (one-port-per-side RAMs).
// One transaction at a time: busy stays high until out_valid has shown.
// Reset: synchronous; after reset a clearing pass writes every map entry
// (2**KEY_BITS of them, 4096 by default) with busy high. Results cannot stall.
`default_nettype none
module packed_component_table #(
  parameter int CAPACITY  = pct_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = pct_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = pct_pkg::DATA_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [2:0]                      in_cmd,
  input  wire logic [KEY_BITS-1:0]             in_entity_key,
  input  wire logic [DATA_BITS-1:0]            in_data_in,
  output logic                                 out_valid,
  output logic      [1:0]                      out_status,
  output logic                                 out_present,
  output logic      [DATA_BITS-1:0]            out_data_out,
  output logic      [$clog2(CAPACITY+1)-1:0]   out_entry_count
);

  import pct_pkg::*;

  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int MAP_W     = SLOT_BITS + 1;
  localparam int DENSE_W   = KEY_BITS + DATA_BITS;
  localparam int MAP_DEPTH = 1 << KEY_BITS;
  localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

  state_t                 state_r, state_nxt;
  logic [KEY_BITS-1:0]    clr_r, clr_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [DATA_BITS-1:0]   data_r, data_nxt;
  logic [SLOT_BITS-1:0]   hole_r, hole_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   present_r, present_nxt;
  logic [DATA_BITS-1:0]   rdata_r, rdata_nxt;

  logic                   map_wr_en;
  logic [KEY_BITS-1:0]    map_wr_addr;
  logic [MAP_W-1:0]       map_wr_data;
  logic                   map_rd_en;
  logic [MAP_W-1:0]       map_rd_data;

  logic                   dense_wr_en;
  logic [SLOT_BITS-1:0]   dense_wr_addr;
  logic [DENSE_W-1:0]     dense_wr_data;
  logic                   dense_rd_en;
  logic [SLOT_BITS-1:0]   dense_rd_addr;
  logic [DENSE_W-1:0]     dense_rd_data;

  logic                   accept;
  logic                   hit;
  logic [SLOT_BITS-1:0]   hit_slot;
  logic [CNT_BITS-1:0]    last_cnt;

  assign accept   = start && (state_r == S_IDLE);
  assign hit      = map_rd_data[SLOT_BITS];
  assign hit_slot = map_rd_data[SLOT_BITS-1:0];
  assign last_cnt = count_r - 1'b1;

  pct_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (in_entity_key),
    .rd_data (map_rd_data)
  );

  pct_ram #(
    .WIDTH (DENSE_W),
    .DEPTH (CAPACITY)
  ) u_dense_ram (
    .clk     (clk),
    .wr_en   (dense_wr_en),
    .wr_addr (dense_wr_addr),
    .wr_data (dense_wr_data),
    .rd_en   (dense_rd_en),
    .rd_addr (dense_rd_addr),
    .rd_data (dense_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    data_r    <= data_nxt;
    hole_r    <= hole_nxt;
    status_r  <= status_nxt;
    present_r <= present_nxt;
    rdata_r   <= rdata_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    data_nxt      = data_r;
    hole_nxt      = hole_r;
    status_nxt    = status_r;
    present_nxt   = present_r;
    rdata_nxt     = rdata_r;
    map_wr_en     = 1'b0;
    map_wr_addr   = key_r;
    map_wr_data   = '0;
    map_rd_en     = 1'b0;
    dense_wr_en   = 1'b0;
    dense_wr_addr = hit_slot;
    dense_wr_data = {key_r, data_r};
    dense_rd_en   = 1'b0;
    dense_rd_addr = hit_slot;

    case (state_r)
      S_CLEAR: begin
        map_wr_en   = 1'b1;
        map_wr_addr = clr_r;
        map_wr_data = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == {KEY_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          map_rd_en = 1'b1;
          cmd_nxt   = in_cmd;
          key_nxt   = in_entity_key;
          data_nxt  = in_data_in;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        present_nxt = hit;
        status_nxt  = ST_OK;
        rdata_nxt   = '0;
        hole_nxt    = hit_slot;
        state_nxt   = S_RESP;
        case (cmd_r)
          CMD_ADD: begin
            if (hit) begin
              status_nxt = ST_DUPLICATE;
            end else if (count_r == CAP_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              dense_wr_en   = 1'b1;
              dense_wr_addr = count_r[SLOT_BITS-1:0];
              map_wr_en     = 1'b1;
              map_wr_addr   = key_r;
              map_wr_data   = {1'b1, count_r[SLOT_BITS-1:0]};
              count_nxt     = count_r + 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (!hit) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              dense_rd_en   = 1'b1;
              dense_rd_addr = last_cnt[SLOT_BITS-1:0];
              state_nxt     = S_RM_MOVE;
            end
          end
          CMD_READ: begin
            if (!hit) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              dense_rd_en = 1'b1;
              state_nxt   = S_RD_WAIT;
            end
          end
          CMD_OVERWRITE: begin
            if (!hit) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              dense_wr_en = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_RM_MOVE: begin
        dense_wr_en   = 1'b1;
        dense_wr_addr = hole_r;
        dense_wr_data = dense_rd_data;
        map_wr_en     = 1'b1;
        map_wr_addr   = dense_rd_data[DENSE_W-1:DATA_BITS];
        map_wr_data   = {1'b1, hole_r};
        state_nxt     = S_RM_CLR;
      end
      S_RM_CLR: begin
        // clear after the move so removing the last slot leaves the key absent
        map_wr_en   = 1'b1;
        map_wr_addr = key_r;
        map_wr_data = '0;
        count_nxt   = last_cnt;
        state_nxt   = S_RESP;
      end
      S_RD_WAIT: begin
        rdata_nxt = dense_rd_data[DATA_BITS-1:0];
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_RESP);
  assign out_status      = status_r;
  assign out_present     = present_r;
  assign out_data_out    = rdata_r;
  assign out_entry_count = count_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && cmd_r == CMD_ADD && !hit && count_r != CAP_CNT)
      |=> count_r == $past(count_r) + 1'b1)
    else $error("add did not advance entry count");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !dense_wr_en && !out_valid)
    else $error("activity during map clearing pass");

endmodule
`default_nettype wire

// File: verif/packed_component_table_tb.sv
`timescale 1ns / 1ps
module packed_component_table_tb;
  import pct_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEF;
  localparam int KEY_BITS   = KEY_BITS_DEF;
  localparam int DATA_BITS  = DATA_BITS_DEF;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int KEY_MAX    = (1 << KEY_BITS) - 1;
  localparam int RAND_ITEMS = 2000;
  localparam int PHASES     = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int PRINT_CAP  = 60;

  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  typedef enum {PH_MIX, PH_FILL, PH_DRAIN} phase_t;

  typedef struct {
    logic [1:0]            status;
    logic                  present;
    logic [DATA_BITS-1:0]  data;
    logic [COUNT_BITS-1:0] count;
  } table_resp_t;

  class component_table_sb;
    bit                   key_live [KEY_MAX+1];
    int unsigned          key_pos  [KEY_MAX+1];
    logic [KEY_BITS-1:0]  pos_key  [CAPACITY];
    logic [DATA_BITS-1:0] pos_word [CAPACITY];
    int unsigned          live;
    int unsigned          peak;
    int unsigned          cmd_seen [8];
    int unsigned          full_rejects;
    int unsigned          dup_rejects;
    int unsigned          misses;
    int unsigned          mismatches;
    table_resp_t          resp_q [$];

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void note_cmd(logic [2:0] cmd, logic [KEY_BITS-1:0] key,
                           logic [DATA_BITS-1:0] word);
      table_resp_t r;
      int unsigned hole;
      int unsigned last;
      r.status  = ST_OK;
      r.present = key_live[key];
      r.data    = '0;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_ADD: begin
          if (r.present) begin
            r.status = ST_DUPLICATE;
            dup_rejects++;
          end else if (live >= CAPACITY) begin
            r.status = ST_FULL;
            full_rejects++;
          end else begin
            pos_word[live] = word;
            pos_key[live]  = key;
            key_pos[key]   = live;
            key_live[key]  = 1'b1;
            live++;
          end
        end
        CMD_REMOVE: begin
          if (!r.present) begin
            r.status = ST_NOT_FOUND;
            misses++;
          end else begin
            // fill the hole with the last live entry and re-point its key
            hole = key_pos[key];
            last = live - 1;
            pos_word[hole]         = pos_word[last];
            pos_key[hole]          = pos_key[last];
            key_pos[pos_key[hole]] = hole;
            key_live[key]          = 1'b0;
            live                   = last;
          end
        end
        CMD_READ: begin
          if (!r.present) begin
            r.status = ST_NOT_FOUND;
            misses++;
          end else begin
            r.data = pos_word[key_pos[key]];
          end
        end
        CMD_OVERWRITE: begin
          if (!r.present) begin
            r.status = ST_NOT_FOUND;
            misses++;
          end else begin
            pos_word[key_pos[key]] = word;
          end
        end
        default: ;
      endcase
      if (live > peak) peak = live;
      r.count = COUNT_BITS'(live);
      resp_q.push_back(r);
    endfunction

    task check_resp(logic [1:0] status, logic present, logic [DATA_BITS-1:0] data,
                    logic [COUNT_BITS-1:0] count);
      table_resp_t r;
      if (resp_q.size() == 0) begin
        flag_mismatch($sformatf("result with no transaction pending, status %0d", status));
        return;
      end
      r = resp_q.pop_front();
      if (status !== r.status)
        flag_mismatch($sformatf("status %0d, expected %0d", status, r.status));
      if (present !== r.present)
        flag_mismatch($sformatf("present %0b, expected %0b", present, r.present));
      if (data !== r.data)
        flag_mismatch($sformatf("data_out %h, expected %h", data, r.data));
      if (count !== r.count)
        flag_mismatch($sformatf("entry_count %0d, expected %0d", count, r.count));
    endtask
  endclass

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic [2:0]            in_cmd        = '0;
  logic [KEY_BITS-1:0]   in_entity_key = '0;
  logic [DATA_BITS-1:0]  in_data_in    = '0;
  logic                  busy;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic                  out_present;
  logic [DATA_BITS-1:0]  out_data_out;
  logic [COUNT_BITS-1:0] out_entry_count;

  component_table_sb sb = new();
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  packed_component_table #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_entity_key  (in_entity_key),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_present    (out_present),
    .out_data_out   (out_data_out),
    .out_entry_count(out_entry_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_resp(out_status, out_present, out_data_out, out_entry_count);
    if (rst_n && start && !busy)
      sb.note_cmd(in_cmd, in_entity_key, in_data_in);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic [KEY_BITS-1:0] key,
                           input logic [DATA_BITS-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_entity_key <= key;
    in_data_in    <= word;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.resp_q.size() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key(int unsigned live_pct);
    if (sb.live != 0 && $urandom_range(0, 99) < live_pct)
      return sb.pos_key[$urandom_range(0, sb.live - 1)];
    return KEY_BITS'($urandom_range(0, KEY_MAX));
  endfunction

  function automatic logic [2:0] draw_cmd(phase_t kind);
    int unsigned roll;
    int unsigned w [5];
    logic [2:0]  codes [5];
    codes = '{CMD_ADD, CMD_REMOVE, CMD_READ, CMD_OVERWRITE, CMD_TEST};
    case (kind)
      PH_FILL:  w = '{80, 4, 6, 5, 4};
      PH_DRAIN: w = '{8, 75, 7, 5, 4};
      default:  w = '{30, 25, 18, 14, 10};
    endcase
    roll = $urandom_range(0, 99);
    foreach (w[i]) begin
      if (roll < w[i]) return codes[i];
      roll -= w[i];
    end
    return 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
  endfunction

  initial begin
    phase_t     plan [PHASES];
    logic [2:0] cmd;
    plan = '{PH_MIX, PH_FILL, PH_FILL, PH_MIX, PH_DRAIN, PH_FILL, PH_DRAIN, PH_MIX};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_item(CMD_ADD,       12'h000, 32'h0000_0000);
    send_item(CMD_ADD,       KEY_BITS'(KEY_MAX), '1);
    send_item(CMD_ADD,       12'h000, 32'h5A5A_5A5A);
    send_item(CMD_READ,      12'h000, $urandom);
    send_item(CMD_READ,      KEY_BITS'(KEY_MAX), $urandom);
    send_item(CMD_READ,      12'h5A5, $urandom);
    send_item(CMD_OVERWRITE, KEY_BITS'(KEY_MAX), 32'hA5A5_A5A5);
    send_item(CMD_OVERWRITE, 12'h123, $urandom);
    send_item(CMD_TEST,      12'h000, $urandom);
    send_item(CMD_TEST,      12'h800, $urandom);
    send_item(CMD_REMOVE,    12'h0F0, $urandom);
    send_item(CMD_REMOVE,    12'h000, $urandom);
    send_item(CMD_READ,      KEY_BITS'(KEY_MAX), $urandom);
    send_item(CMD_READ,      12'h000, $urandom);
    send_item(CMD_REMOVE,    KEY_BITS'(KEY_MAX), $urandom);
    send_item(CMD_REMOVE,    KEY_BITS'(KEY_MAX), $urandom);
    send_item(CMD_READ,      KEY_BITS'(KEY_MAX), $urandom);
    send_item(CMD_RSVD_A,    pick_key(0), $urandom);
    send_item(CMD_RSVD_B,    pick_key(0), $urandom);
    send_item(CMD_RSVD_C,    pick_key(0), $urandom);
    send_item(CMD_ADD,       12'hAAA, 32'h8000_0001);
    send_item(CMD_ADD,       12'h555, 32'h7FFF_FFFE);
    send_item(CMD_REMOVE,    12'h555, $urandom);
    send_item(CMD_OVERWRITE, 12'hAAA, 32'h0000_0000);
    send_item(CMD_READ,      12'hAAA, $urandom);

    for (int p = 0; p < PHASES; p++) begin
      hold_until_drained();
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        cmd = draw_cmd(plan[p]);
        send_item(cmd, pick_key(cmd == CMD_ADD ? (plan[p] == PH_FILL ? 8 : 30) : 85),
                  $urandom);
      end
    end

    hold_until_drained();
    repeat (12) @(negedge clk);

    $display("Covered %0d add, %0d remove, %0d read, %0d overwrite, %0d test, %0d unused-code",
             sb.cmd_seen[CMD_ADD], sb.cmd_seen[CMD_REMOVE], sb.cmd_seen[CMD_READ],
             sb.cmd_seen[CMD_OVERWRITE], sb.cmd_seen[CMD_TEST],
             sb.cmd_seen[CMD_RSVD_A] + sb.cmd_seen[CMD_RSVD_B] + sb.cmd_seen[CMD_RSVD_C]);
    $display("Peak %0d entries, %0d full rejects, %0d duplicate adds, %0d misses, %0d mismatches",
             sb.peak, sb.full_rejects, sb.dup_rejects, sb.misses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
